// ===== src/stamh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stamh_pkg
// Shared widths, record types and the tanh(2x) table for the spectrum trace
// average / max hold unit.
// ----------------------------------------------------------------------------
package stamh_pkg;

  localparam int BIN_W    = 10;
  localparam int NORM_W   = 24;
  localparam int CNT_W    = 16;
  localparam int AVG_W    = 21;          // Q4.16
  localparam int DISP_W   = 16;          // Q0.15
  localparam int DIV_W    = AVG_W + 1;   // quotient bits of the average update
  localparam int REM_W    = CNT_W;
  localparam int FRAC_W   = 13;
  localparam int TAB_LAST = 23;
  localparam int BASE_W   = 15;
  localparam int TPROD_W  = BASE_W + FRAC_W;

  localparam int AVG_MAX  = 1048575;
  localparam int AVG_MIN  = -1048576;
  localparam int AVG_ONE  = 65536;

  localparam int                 NORM_RST = 262144;
  localparam int                 CNT_RST  = 1;
  localparam logic signed [15:0] HOLD_RST = 16'sh8000;

  // register select, taken from paddr[2]
  localparam logic REG_NORM = 1'b0;
  localparam logic REG_CNT  = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             act;       // bin in range, touches state
    logic             last;
    logic             hold_upd;
    logic [BIN_W-1:0] bin;
  } ctl_t;

  typedef struct packed {
    logic                     avg_vld;
    logic signed [AVG_W-1:0]  avg;
    logic signed [DISP_W-1:0] hold;
  } st_word_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic                     seed;
    logic                     neg;
    logic signed [AVG_W-1:0]  amp;
    logic signed [AVG_W-1:0]  avg_old;
    logic signed [DISP_W-1:0] hold_old;
  } dv_pl_t;

  typedef struct packed {
    dv_pl_t           pl;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dq;        // dividend bits shift out, quotient bits in
  } dv_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin;
    logic signed [DISP_W-1:0] disp;
    logic signed [DISP_W-1:0] held;
  } res_t;

  function automatic logic [BASE_W-1:0] tanh_tab(input logic [4:0] i);
    logic [BASE_W-1:0] v;
    case (i)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd8026;
      5'd2:    v = 15'd15143;
      5'd3:    v = 15'd20813;
      5'd4:    v = 15'd24956;
      5'd5:    v = 15'd27797;
      5'd6:    v = 15'd29660;
      5'd7:    v = 15'd30847;
      5'd8:    v = 15'd31589;
      5'd9:    v = 15'd32048;
      5'd10:   v = 15'd32329;
      5'd11:   v = 15'd32501;
      5'd12:   v = 15'd32606;
      5'd13:   v = 15'd32670;
      5'd14:   v = 15'd32708;
      5'd15:   v = 15'd32732;
      5'd16:   v = 15'd32746;
      5'd17:   v = 15'd32755;
      5'd18:   v = 15'd32760;
      5'd19:   v = 15'd32763;
      5'd20:   v = 15'd32765;
      5'd21:   v = 15'd32766;
      5'd22:   v = 15'd32767;
      default: v = 15'd32767;
    endcase
    return v;
  endfunction

endpackage

// ===== src/stamh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stamh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stamh_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/spectrum_trace_average_max_hold_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_trace_average_max_hold_unit
// Per-bin batch sum, exponential average, tanh display and max hold.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one spectrum sample per
//    request, batch-major. Items that close a batch sum produce one result
//    on the output channel (out_valid_o/out_ready_i); others produce none.
//  - Throughput: one request per cycle when nothing holds the pipeline. A
//    request whose bin is still in flight waits until that bin leaves the
//    pipeline (per-bin state is read at entry and written back at the
//    end).
//  - The average update divides by average_count in a 22-stage restoring
//    divider, one quotient bit per stage; it sets most of the latency.
//  - After reset the unit sweeps the average / hold memory, one bin per
//    cycle, with in_ready_o low. APB writes work throughout.
//  - Output stall: a two-entry result buffer absorbs results; when it is
//    full the whole pipeline holds and in_ready_o drops. Nothing is lost.
//  - Registers: 0x0 norm_factor, 0x4 average_count. Write only while idle.
// ----------------------------------------------------------------------------
module spectrum_trace_average_max_hold_unit
  import stamh_pkg::*;
#(
  parameter int BINS        = 1024,
  parameter int MAX_BATCHES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [BIN_W-1:0]              bin_index_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          first_batch_i,
  input  wire logic                          last_batch_i,
  input  wire logic                          hold_update_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [BIN_W-1:0]              out_bin_o,
  output logic signed [DISP_W-1:0]           displayed_o,
  output logic signed [DISP_W-1:0]           held_o
);

  localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SUM_W  = $clog2(MAX_BATCHES) + SAMPLE_BITS;
  localparam int PROD_W = SUM_W + NORM_W + 1;
  localparam int RND_SH = SAMPLE_BITS + 6;
  localparam int NSTG   = DIV_W + 8;
  localparam int ST_W   = $bits(st_word_t);

  localparam logic signed [SUM_W:0] SUM_LIM =
    (SUM_W + 1)'(MAX_BATCHES) << (SAMPLE_BITS - 1);
  localparam logic signed [PROD_W:0] RND_C = (PROD_W + 1)'(1) << (SAMPLE_BITS + 5);

  typedef struct packed {
    ctl_t                          ctl;
    logic                          first;
    logic signed [SAMPLE_BITS-1:0] sample;
  } s1_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic signed [SUM_W-1:0] sum;
    st_word_t                st;
  } s2_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic signed [PROD_W-1:0] prod;
    st_word_t                 st;
  } s3_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic signed [AVG_W-1:0] amp;
    st_word_t                st;
  } s4_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic signed [AVG_W-1:0]  avg;
    logic signed [DISP_W-1:0] hold_old;
  } s5_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic signed [AVG_W-1:0]  avg;
    logic signed [DISP_W-1:0] hold_old;
    logic                     neg;
    logic [BASE_W-1:0]        base;
    logic [TPROD_W-1:0]       tprod;
  } s6_t;

  typedef struct packed {
    ctl_t                     ctl;
    logic signed [AVG_W-1:0]  avg;
    logic signed [DISP_W-1:0] hold_old;
    logic signed [DISP_W-1:0] disp;
  } s7_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [NORM_W-1:0] norm_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  n_eff;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= NORM_W'(NORM_RST);
      cnt_q  <= CNT_W'(CNT_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NORM: norm_q <= pwdata[NORM_W-1:0];
        REG_CNT:  cnt_q  <= pwdata[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NORM: prdata = 32'(norm_q);
      REG_CNT:  prdata = 32'(cnt_q);
      default:  prdata = '0;
    endcase
  end

  assign n_eff = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  s4_t  s4_q, s4_d;
  dv_t  dv_q [DIV_W+1];
  dv_t  dv_d [DIV_W+1];
  s5_t  s5_q, s5_d;
  s6_t  s6_q, s6_d;
  s7_t  s7_q;

  logic [1:0]       fcnt_q;
  logic             adv;
  logic             haz;
  logic             accept;
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_cnt_q;
  ctl_t             fl [NSTG];

  assign adv        = (fcnt_q != 2'd2);
  assign in_ready_o = adv && !clr_busy_q && !haz;
  assign accept     = in_valid_i && in_ready_o;

  // a request must not overtake a pending write-back to the same bin
  always_comb begin
    fl[0] = s1_q.ctl;
    fl[1] = s2_q.ctl;
    fl[2] = s3_q.ctl;
    fl[3] = s4_q.ctl;
    for (int k = 0; k <= DIV_W; k++) begin
      fl[4+k] = dv_q[k].pl.ctl;
    end
    fl[NSTG-3] = s5_q.ctl;
    fl[NSTG-2] = s6_q.ctl;
    fl[NSTG-1] = s7_q.ctl;
    haz = 1'b0;
    for (int k = 0; k < NSTG; k++) begin
      haz = haz || (fl[k].vld && fl[k].act && (fl[k].bin == bin_index_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      if (clr_cnt_q == IDX_W'(BINS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_rdata;
  logic             sum_we;
  logic [ST_W-1:0]  st_rdata;
  st_word_t         st_rd;
  st_word_t         st_wdata;
  logic [IDX_W-1:0] st_waddr;
  logic             st_we;
  logic             pipe_we;
  logic signed [DISP_W-1:0] new_hold;

  assign sum_we  = s1_q.ctl.vld && s1_q.ctl.act && adv;
  assign pipe_we = s7_q.ctl.vld && s7_q.ctl.act && s7_q.ctl.last && adv;
  assign st_we   = clr_busy_q || pipe_we;
  assign st_rd   = st_word_t'(st_rdata);

  always_comb begin
    if (clr_busy_q) begin
      st_waddr = clr_cnt_q;
      st_wdata = '{avg_vld: 1'b0, avg: '0, hold: HOLD_RST};
    end else begin
      st_waddr = IDX_W'(s7_q.ctl.bin);
      st_wdata = '{avg_vld: 1'b1, avg: s7_q.avg, hold: new_hold};
    end
  end

  stamh_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BINS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (IDX_W'(s1_q.ctl.bin)),
    .wdata_i (s2_d.sum),
    .re_i    (accept),
    .raddr_i (IDX_W'(bin_index_i)),
    .rdata_o (sum_rdata)
  );

  stamh_ram #(
    .WIDTH (ST_W),
    .DEPTH (BINS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (accept),
    .raddr_i (IDX_W'(bin_index_i)),
    .rdata_o (st_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [SUM_W:0]   tot;
  logic signed [PROD_W:0]  pr_sh;
  logic signed [AVG_W:0]   diff;
  logic [DIV_W-1:0]        dmag;
  logic [DIV_W:0]          dvd;
  logic signed [AVG_W+2:0] upd;
  logic [DIV_W+1:0]        qx;
  logic [AVG_W-1:0]        amag;
  logic [7:0]              aidx;
  logic [FRAC_W-1:0]       afrac;
  logic [BASE_W-1:0]       tb0;
  logic [BASE_W-1:0]       tdl;
  logic [TPROD_W:0]        trnd;
  logic signed [DISP_W-1:0] tv;

  // stage 1: input capture
  always_comb begin
    s1_d.ctl.vld      = accept;
    s1_d.ctl.act      = (32'(bin_index_i) < BINS);
    s1_d.ctl.last     = last_batch_i;
    s1_d.ctl.hold_upd = hold_update_i;
    s1_d.ctl.bin      = bin_index_i;
    s1_d.first        = first_batch_i;
    s1_d.sample       = sample_i;
  end

  // stage 2: saturating batch sum
  always_comb begin
    tot = (SUM_W + 1)'(s1_q.sample);
    if (!s1_q.first) begin
      tot = tot + (SUM_W + 1)'($signed(sum_rdata));
    end
    if (tot > SUM_LIM - (SUM_W + 1)'(1)) begin
      tot = SUM_LIM - (SUM_W + 1)'(1);
    end else if (tot < -SUM_LIM) begin
      tot = -SUM_LIM;
    end
    s2_d.ctl = s1_q.ctl;
    s2_d.sum = tot[SUM_W-1:0];
    s2_d.st  = st_rd;
  end

  // stage 3: sum * norm
  always_comb begin
    s3_d.ctl  = s2_q.ctl;
    s3_d.prod = s2_q.sum * $signed({1'b0, norm_q});
    s3_d.st   = s2_q.st;
  end

  // stage 4: round to Q4.16, remove the unit offset, saturate
  always_comb begin
    pr_sh = ((PROD_W + 1)'(s3_q.prod) + RND_C) >>> RND_SH;
    pr_sh = pr_sh - (PROD_W + 1)'(AVG_ONE);
    if (pr_sh > (PROD_W + 1)'(AVG_MAX)) begin
      pr_sh = (PROD_W + 1)'(AVG_MAX);
    end else if (pr_sh < (PROD_W + 1)'(AVG_MIN)) begin
      pr_sh = (PROD_W + 1)'(AVG_MIN);
    end
    s4_d.ctl = s3_q.ctl;
    s4_d.amp = pr_sh[AVG_W-1:0];
    s4_d.st  = s3_q.st;
  end

  // divider entry: |amp - avg| + n/2, rounded to nearest by the divide,
  // then a restoring divider, one quotient bit per stage
  always_comb begin
    logic [REM_W:0] t;
    logic           ge;
    diff = (AVG_W + 1)'(s4_q.amp) - (AVG_W + 1)'(s4_q.st.avg);
    dmag = diff[AVG_W] ? DIV_W'(-diff) : DIV_W'(diff);
    dvd  = (DIV_W + 1)'(dmag) + (DIV_W + 1)'(n_eff >> 1);
    dv_d[0].pl.ctl      = s4_q.ctl;
    dv_d[0].pl.seed     = !s4_q.st.avg_vld;
    dv_d[0].pl.neg      = diff[AVG_W];
    dv_d[0].pl.amp      = s4_q.amp;
    dv_d[0].pl.avg_old  = s4_q.st.avg;
    dv_d[0].pl.hold_old = s4_q.st.hold;
    dv_d[0].rem         = '0;
    dv_d[0].dq          = dvd[DIV_W-1:0];
    for (int k = 0; k < DIV_W; k++) begin
      t  = {dv_q[k].rem, dv_q[k].dq[DIV_W-1]};
      ge = (t >= {1'b0, n_eff});
      dv_d[k+1].pl  = dv_q[k].pl;
      dv_d[k+1].rem = ge ? REM_W'(t - {1'b0, n_eff}) : t[REM_W-1:0];
      dv_d[k+1].dq  = {dv_q[k].dq[DIV_W-2:0], ge};
    end
  end

  // stage 5: new average
  always_comb begin
    qx  = {2'b00, dv_q[DIV_W].dq};
    upd = (AVG_W + 3)'(dv_q[DIV_W].pl.avg_old);
    if (dv_q[DIV_W].pl.neg) begin
      upd = upd - $signed(qx);
    end else begin
      upd = upd + $signed(qx);
    end
    if (upd > (AVG_W + 3)'(AVG_MAX)) begin
      upd = (AVG_W + 3)'(AVG_MAX);
    end else if (upd < (AVG_W + 3)'(AVG_MIN)) begin
      upd = (AVG_W + 3)'(AVG_MIN);
    end
    s5_d.ctl      = dv_q[DIV_W].pl.ctl;
    s5_d.avg      = dv_q[DIV_W].pl.seed ? dv_q[DIV_W].pl.amp : upd[AVG_W-1:0];
    s5_d.hold_old = dv_q[DIV_W].pl.hold_old;
  end

  // stage 6: table lookup and slope * fraction
  always_comb begin
    amag  = s5_q.avg[AVG_W-1] ? AVG_W'(-s5_q.avg) : AVG_W'(s5_q.avg);
    aidx  = amag[AVG_W-1:FRAC_W];
    afrac = amag[FRAC_W-1:0];
    if (aidx >= 8'(TAB_LAST)) begin
      tb0 = BASE_W'(32767);
      tdl = '0;
    end else begin
      tb0 = tanh_tab(aidx[4:0]);
      tdl = tanh_tab(aidx[4:0] + 5'd1) - tb0;
    end
    s6_d.ctl      = s5_q.ctl;
    s6_d.avg      = s5_q.avg;
    s6_d.hold_old = s5_q.hold_old;
    s6_d.neg      = s5_q.avg[AVG_W-1];
    s6_d.base     = tb0;
    s6_d.tprod    = TPROD_W'(tdl) * TPROD_W'(afrac);
  end

  // stage 7: interpolate and sign
  always_comb begin
    trnd = (TPROD_W + 1)'(s6_q.tprod) + (TPROD_W + 1)'(1 << (FRAC_W - 1));
    tv   = $signed(DISP_W'(s6_q.base) + DISP_W'(trnd >> FRAC_W));
  end

  // max hold update feeds the write-back and the result
  assign new_hold = (s7_q.ctl.hold_upd && (s7_q.disp > s7_q.hold_old)) ?
                    s7_q.disp : s7_q.hold_old;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      for (int k = 0; k <= DIV_W; k++) begin
        dv_q[k] <= '0;
      end
      s5_q <= '0;
      s6_q <= '0;
      s7_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      for (int k = 0; k <= DIV_W; k++) begin
        dv_q[k] <= dv_d[k];
      end
      s5_q <= s5_d;
      s6_q <= s6_d;
      s7_q.ctl      <= s6_q.ctl;
      s7_q.avg      <= s6_q.avg;
      s7_q.hold_old <= s6_q.hold_old;
      s7_q.disp     <= s6_q.neg ? -tv : tv;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer
  // --------------------------------------------------------------------------
  res_t fifo_q [2];
  logic wr_ptr_q;
  logic rd_ptr_q;
  logic push;
  logic pop;

  assign push = pipe_we;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fcnt_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{bin: s7_q.ctl.bin, disp: s7_q.disp, held: new_hold};
    end
  end

  assign out_valid_o = (fcnt_q != 2'd0);
  assign out_bin_o   = fifo_q[rd_ptr_q].bin;
  assign displayed_o = fifo_q[rd_ptr_q].disp;
  assign held_o      = fifo_q[rd_ptr_q].held;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fcnt_q != 2'd2))
    else $error("result pushed into full buffer");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("request accepted during memory sweep");

  a_no_we_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pipe_we)
    else $error("pipeline write-back during memory sweep");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DIV_W].pl.ctl.vld |-> (dv_q[DIV_W].rem < n_eff))
    else $error("divider remainder out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && s7_q.ctl.vld) |=> ($stable(s7_q.disp) && s7_q.ctl.vld))
    else $error("final stage changed while stalled");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum trace average / max hold testbench
// Drives batch-major spectrum samples through the valid/ready input channel,
// predicts each trace result (batch sum, amplitude, exponential average,
// tanh display, max hold) and checks it field by field at the output. APB
// writes sweep the scale and the average length between phases.
// ----------------------------------------------------------------------------
module tb
  import stamh_pkg::*;
();

  localparam int NBINS      = 1024;
  localparam int SUM_LIM    = 64 * 32768;
  localparam int LATENCY    = 40;
  localparam int CYCLE_CAP  = 2000000;
  localparam int LONG_STALL = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [BIN_W-1:0] bin_index_i = '0;
  logic signed [15:0] sample_i = '0;
  logic first_batch_i = 1'b0, last_batch_i = 1'b0, hold_update_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [BIN_W-1:0] out_bin_o;
  logic signed [DISP_W-1:0] displayed_o, held_o;

  spectrum_trace_average_max_hold_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [23:0] norm_q = NORM_W'(NORM_RST);
  logic [15:0] avg_len_q = CNT_W'(CNT_RST);
  longint sum_mem [NBINS];
  int avg_mem [NBINS];
  bit avg_set [NBINS];
  int hold_mem [NBINS];
  bit sum_written [NBINS];
  res_t trace_q [$];

  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  int stall_hold = 0;
  bit long_req = 1'b0;
  bit long_ack = 1'b0;
  int long_cnt = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint fdiv_pow2(longint x, int n);
    return x >>> n;   // arithmetic shift floors
  endfunction

  function automatic int tanh_val(int i);
    int t [24] = '{0, 8026, 15143, 20813, 24956, 27797, 29660, 30847,
                   31589, 32048, 32329, 32501, 32606, 32670, 32708, 32732,
                   32746, 32755, 32760, 32763, 32765, 32766, 32767, 32767};
    return t[i];
  endfunction

  function automatic int tanh2(int a);
    int mag, idx, frac, v, lo, hi;
    mag = a < 0 ? -a : a;
    idx = mag >> 13;
    frac = mag & 8191;
    if (idx >= TAB_LAST) v = 32767;
    else begin
      lo = tanh_val(idx);
      hi = tanh_val(idx + 1);
      v = lo + (((hi - lo) * frac + 4096) >> 13);
    end
    return a < 0 ? -v : v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // applies one accepted sample to the trace state, queues any result
  task automatic update_trace(int bin, int smp, bit first, bit last, bit hupd);
    longint s, q, amp, avg, diff, mag, n;
    int disp;
    res_t r;
    s = longint'($signed(16'(smp)));
    if (!first) s += sum_mem[bin];
    s = clip(s, -SUM_LIM, SUM_LIM - 1);
    sum_mem[bin] = s;
    if (!last) return;
    q = s * longint'(norm_q >> 12) + fdiv_pow2(s * longint'(norm_q & 24'hfff), 12);
    amp = fdiv_pow2(q + 512, 10);
    amp = clip(amp - AVG_ONE, AVG_MIN, AVG_MAX);
    if (!avg_set[bin]) begin
      avg = amp;
      avg_set[bin] = 1'b1;
    end else begin
      diff = amp - avg_mem[bin];
      mag = diff < 0 ? -diff : diff;
      n = avg_len_q == 0 ? 1 : avg_len_q;
      mag = (mag + n / 2) / n;
      avg = clip(avg_mem[bin] + (diff < 0 ? -mag : mag), AVG_MIN, AVG_MAX);
    end
    avg_mem[bin] = int'(avg);
    disp = tanh2(int'(avg));
    if (hupd && disp > hold_mem[bin]) hold_mem[bin] = disp;
    r.bin = BIN_W'(bin);
    r.disp = DISP_W'(disp);
    r.held = DISP_W'(hold_mem[bin]);
    trace_q.push_back(r);
  endtask

  task automatic send_sample(int bin, int smp, bit first, bit last, bit hupd);
    if (!first && !sum_written[bin]) first = 1'b1;   // never read an unset sum
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_index_i <= BIN_W'(bin);
    sample_i <= 16'(smp);
    first_batch_i <= first;
    last_batch_i <= last;
    hold_update_i <= hupd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sum_written[bin] = 1'b1;
    update_trace(bin, smp, first, last, hupd);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (trace_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, int val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NORM) norm_q = NORM_W'(val); else avg_len_q = CNT_W'(val);
  endtask

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (long_req != long_ack) begin
      long_ack <= long_req;
      long_cnt <= LONG_STALL;
    end else if (long_cnt > 0) long_cnt <= long_cnt - 1;
  end

  // output side: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    if (long_cnt > 0) begin
      out_ready_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_hold <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (trace_q.size() == 0) begin
        $display("%0t: unexpected result bin %0d", $realtime, out_bin_o);
        errors++;
      end else begin
        exp_r = trace_q.pop_front();
        if (out_bin_o !== exp_r.bin || displayed_o !== exp_r.disp || held_o !== exp_r.held) begin
          $display("%0t: mismatch expected bin %0d disp %0d held %0d, got %0d %0d %0d",
                   $realtime, exp_r.bin, exp_r.disp, exp_r.held,
                   out_bin_o, displayed_o, held_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_sample(0, 32767, 1, 1, 1);
    send_sample(1023, -32768, 1, 1, 1);
    send_sample(5, 16384, 1, 0, 0);
    send_sample(5, 16384, 0, 0, 0);
    send_sample(5, -1, 0, 1, 1);
    send_sample(0, 0, 1, 1, 0);
    send_sample(0, -32768, 1, 1, 1);
    send_sample(1023, 32767, 1, 1, 0);
    for (int i = 0; i < 70; i++) send_sample(7, 32767, i == 0, i == 69, 1);
    for (int i = 0; i < 70; i++) send_sample(8, -32768, i == 0, i == 69, 1);
    send_sample(682, 21845, 1, 1, 1);
    send_sample(341, -21846, 1, 1, 0);
  endtask

  task automatic test_config_extremes();
    apb_write(REG_NORM, 24'hffffff);
    apb_write(REG_CNT, 16'hffff);
    for (int b = 20; b < 24; b++) send_sample(b, $urandom_range(0, 65535), 1, 1, 1);
    for (int b = 20; b < 24; b++) send_sample(b, $urandom_range(0, 65535), 1, 1, 1);
    wait_drain();
    apb_write(REG_NORM, 0);
    apb_write(REG_CNT, 0);
    for (int b = 20; b < 24; b++) send_sample(b, $urandom_range(0, 65535), 1, 1, 1);
    wait_drain();
  endtask

  // whole frames: every bin in a small set, one to four batches each
  task automatic random_frames(int n_items);
    int nb, base, sent;
    sent = 0;
    while (sent < n_items) begin
      nb = $urandom_range(1, 4);
      base = $urandom_range(0, NBINS - 8);
      for (int bt = 0; bt < nb; bt++)
        for (int k = 0; k < 8; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_sample($urandom_range(0, NBINS - 1), $urandom_range(0, 65535),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          else
            send_sample(base + k, $urandom_range(0, 65535), bt == 0, bt == nb - 1,
                        $urandom_range(0, 3) != 0);
          sent++;
        end
    end
  endtask

  task automatic test_random_phases();
    int norms [4] = '{262144, 16777215, 65536, 4194304};
    for (int p = 0; p < 4; p++) begin
      apb_write(REG_NORM, norms[p]);
      apb_write(REG_CNT, p == 0 ? 1 : $urandom_range(1, 65535) >> ($urandom_range(0, 15)));
      random_frames(350);
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    long_req = !long_req;
    for (int i = 0; i < 40; i++) send_sample(100 + i, $urandom_range(0, 65535), 1, 1, 1);
    wait_drain();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    apb_write(REG_CNT, 3);
    random_frames(200);
  endtask

  initial begin
    for (int i = 0; i < NBINS; i++) begin
      sum_mem[i] = 0; avg_mem[i] = 0; avg_set[i] = 0;
      hold_mem[i] = -32768; sum_written[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    wait_drain();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    test_no_idle();
    wait_drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
src/stamh_pkg.sv
src/stamh_ram.sv
src/spectrum_trace_average_max_hold_unit.sv
verif/tb.sv
